// File: hw/rtl/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH
// property holds at every clock edge
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequence holds in the cycle after the antecedent
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Transfer payload types, compressor control types and SHA-256 constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	// control from the byte sequencer to the compressor
	typedef struct packed {
		logic init;   // reload initial hash value
		logic push;   // shift one message word into the schedule
		logic start;  // begin 64 rounds on the loaded block
	} cmp_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;   // hash words update at this edge
	} cmp_stat_t;

	localparam hash_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// File: hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with in-line padding and eight-word digest output.
// ----------------------------------------------------------------------------
//  channel | fields                                   | handshake
//  --------+------------------------------------------+-----------------------
//  msg     | data_byte, has_byte, end_of_message      | msg_valid / msg_stall
//  dig     | digest_word, word_index, last_word       | dig_valid / dig_stall
//
//  Bytes are taken back to back while idle; every 64th byte stalls msg
//  while the compressor runs (64 rounds on the single round unit plus
//  the hash add). End of message pads one byte a cycle (paused while a
//  block compresses) up to the length field, then runs one or two more blocks.
//  msg_stall is high whenever the sequencer is not idle. The digest sits in
//  an output register, so a stalled dig side holds the eight-word readout.
//  Reset loads the initial hash value; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sha256_pkg::msg_t  msg,
	output logic              dig_valid,
	input  logic              dig_stall,
	output sha256_pkg::dig_t  dig
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_COMP,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [5:0]  pos_q;
	logic [23:0] word_q;
	logic [63:0] bit_len_q;
	logic        mark_q;
	logic        pad_q;
	logic        final_q;
	logic [2:0]  idx_q;
	dig_t        dig_q;
	logic        dig_valid_q;

	logic       accept;
	logic       pb_en;
	logic [7:0] pb_byte;
	logic       load;
	cmp_ctrl_t  cmp_ctrl;
	cmp_stat_t  cmp_stat;
	word_t      push_word;
	hash_t      hash;

	assign accept    = msg_valid && (state_q == ST_IDLE);
	assign msg_stall = (state_q != ST_IDLE);
	assign load      = (state_q == ST_OUT) && (!dig_valid_q || !dig_stall);

	always_comb begin
		pb_en   = 1'b0;
		pb_byte = msg.data_byte;
		case (state_q)
			ST_IDLE: pb_en = accept && msg.has_byte;
			ST_PAD: begin
				pb_en   = mark_q || (pos_q != LEN_POS);
				pb_byte = mark_q ? PAD_MARK : 8'h00;
			end
			default: pb_en = 1'b0;
		endcase

		cmp_ctrl.push  = (pb_en && pos_q[1:0] == 2'd3)
			|| state_q == ST_LEN_HI || state_q == ST_LEN_LO;
		cmp_ctrl.start = (pb_en && pos_q == 6'd63) || state_q == ST_LEN_LO;
		cmp_ctrl.init  = load && (idx_q == 3'd7);

		case (state_q)
			ST_LEN_HI: push_word = bit_len_q[63:32];
			ST_LEN_LO: push_word = bit_len_q[31:0];
			default:   push_word = {word_q, pb_byte};
		endcase
	end

	sha256_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (cmp_ctrl),
		.push_word (push_word),
		.stat      (cmp_stat),
		.hash      (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			word_q      <= '0;
			bit_len_q   <= '0;
			mark_q      <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			idx_q       <= '0;
			dig_q       <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			if (pb_en) begin
				pos_q  <= pos_q + 6'd1;
				word_q <= {word_q[15:0], pb_byte};
			end

			if (load) begin
				dig_q.digest_word <= hash[idx_q];
				dig_q.word_index  <= idx_q;
				dig_q.last_word   <= (idx_q == 3'd7);
				dig_valid_q       <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (msg.has_byte)
							bit_len_q <= bit_len_q + 64'd8;
						mark_q <= msg.end_of_message;
						pad_q  <= msg.end_of_message;
						if (cmp_ctrl.start)
							state_q <= ST_COMP;
						else if (msg.end_of_message)
							state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (pb_en) begin
						mark_q <= 1'b0;
						if (cmp_ctrl.start)
							state_q <= ST_COMP;
					end else begin
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: state_q <= ST_LEN_LO;
				ST_LEN_LO: begin
					pos_q   <= '0;
					final_q <= 1'b1;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (cmp_stat.done) begin
						if (final_q) begin
							idx_q   <= '0;
							state_q <= ST_OUT;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (load) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							bit_len_q <= '0;
							pos_q     <= '0;
							final_q   <= 1'b0;
							pad_q     <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	`SHA_ASSERT(a_comp_busy, state_q != ST_COMP || cmp_stat.busy, "waiting on idle compressor")
	`SHA_ASSERT(a_out_idle, state_q != ST_OUT || !cmp_stat.busy, "readout during compression")
	`SHA_ASSERT(a_len_bytes, bit_len_q[2:0] == 3'd0, "bit length not whole bytes")
	`SHA_ASSERT_NEXT(a_final_out, state_q == ST_COMP && cmp_stat.done && final_q, state_q == ST_OUT && idx_q == 3'd0, "final block not followed by readout")

endmodule

// File: hw/rtl/sha256_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compressor
// One round unit run 64 times per block; 16-word schedule shift line.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module sha256_compress (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::cmp_ctrl_t  ctrl,
	input  sha256_pkg::word_t      push_word,
	output sha256_pkg::cmp_stat_t  stat,
	output sha256_pkg::hash_t      hash
);
	import sha256_pkg::*;

	typedef enum logic [1:0] {
		CP_IDLE,
		CP_ROUND,
		CP_ADD
	} cp_state_t;

	cp_state_t  phase_q;
	logic [5:0] cnt_q;
	hash_t      hash_q;
	hash_t      vars_q;
	word_t      w_q [16];

	word_t t1, t2, w_next;
	hash_t vars_next;

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	always_comb begin
		t1 = vars_q[7]
			+ (rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25))
			+ ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
			+ round_k(cnt_q) + w_q[0];
		t2 = (rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22))
			+ ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
		vars_next    = {vars_q[6:0], 32'h0};
		vars_next[0] = t1 + t2;
		vars_next[4] = vars_q[3] + t1;
		// w[t+16] from taps t, t+1, t+9, t+14
		w_next = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10))
			+ w_q[9]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CP_IDLE;
			cnt_q   <= '0;
			hash_q  <= H_INIT;
		end else begin
			case (phase_q)
				CP_IDLE: begin
					if (ctrl.start) begin
						phase_q <= CP_ROUND;
						cnt_q   <= '0;
					end
				end
				CP_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						phase_q <= CP_ADD;
				end
				CP_ADD: begin
					phase_q <= CP_IDLE;
					for (int i = 0; i < 8; i++)
						hash_q[i] <= hash_q[i] + vars_q[i];
				end
				default: phase_q <= CP_IDLE;
			endcase
			if (ctrl.init)
				hash_q <= H_INIT;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start)
			vars_q <= hash_q;
		else if (phase_q == CP_ROUND)
			vars_q <= vars_next;

		if (ctrl.push || phase_q == CP_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= ctrl.push ? push_word : w_next;
		end
	end

	assign stat.busy = (phase_q != CP_IDLE);
	assign stat.done = (phase_q == CP_ADD);
	assign hash      = hash_q;

	`SHA_ASSERT(a_no_start_busy, !(ctrl.start && phase_q != CP_IDLE), "start while busy")
	`SHA_ASSERT(a_no_push_busy, !(ctrl.push && phase_q != CP_IDLE), "push during rounds")
	`SHA_ASSERT_NEXT(a_last_round, phase_q == CP_ROUND && cnt_q == 6'd63, phase_q == CP_ADD, "no add after round 63")

endmodule
